[rtl/aes_pkg.sv]
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam logic [7:0]  GfPoly    = 8'h1B;
  localparam logic [7:0]  GfTop     = 8'h80;

  localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW  = 2'd1;

  typedef logic [127:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ ((a & GfTop) != 8'h00 ? GfPoly : 8'h00);
  endfunction

  // Byte i of a block sits at bits [127-8i -: 8].
  function automatic logic [7:0] get_byte(input block_t b, input int i);
    return b[127 - 8*i -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(c*4+r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, c*4);
      a1 = get_byte(s, c*4+1);
      a2 = get_byte(s, c*4+2);
      a3 = get_byte(s, c*4+3);
      t[127 - 8*(c*4)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[127 - 8*(c*4+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[127 - 8*(c*4+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[127 - 8*(c*4+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return t;
  endfunction

  // One step of the key schedule: previous round key to next one.
  function automatic block_t next_key(input block_t k, input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

[rtl/aes_stream_if.sv]
interface aes_stream_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  modport source (output valid, output data_high, output data_low, input ready);
  modport sink   (input valid, input data_high, input data_low, output ready);
endinterface

[rtl/aes_cfg_if.sv]
interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/aes_round.sv]
module aes_round (
  input  logic              clk,
  input  logic              en,
  input  logic              last,
  input  aes_pkg::block_t   state_i,
  input  aes_pkg::block_t   rkey_i,
  output aes_pkg::block_t   state_o
);
  import aes_pkg::*;

  block_t sub_w, mix_w;
  block_t state_r;

  assign sub_w = sub_shift(state_i);
  assign mix_w = last ? sub_w : mix_columns(sub_w);

  // Hold when the pipeline stalls.
  always_ff @(posedge clk) begin
    if (en) begin
      state_r <= mix_w ^ rkey_i;
    end
  end

  assign state_o = state_r;
endmodule

[rtl/aes128_block_encrypt.sv]
// Channel  | Role   | Payload
// ---------+--------+-------------------------------------------
// in_      | sink   | data_high/low = plain_high/low
// out_     | source | data_high/low = cipher_high/low
// cfg_     | sink   | index (0 key_high, 1 key_low), data
//
// One block per cycle sustained while out_ is not stalled and no key sweep
// runs; one stage for the initial key addition, then one stage per cipher round.
// Round keys are expanded once per key write into registers by a
// sequencer, one schedule step per cycle; input is held off during that
// sweep and during the sweep that follows reset.
// A stall on out_ freezes every stage; nothing is lost or repeated.
module aes128_block_encrypt (
  input logic         clk,
  input logic         rst_n,
  aes_stream_if.sink   in_ch,
  aes_stream_if.source out_ch,
  aes_cfg_if.sink      cfg_ch
);
  import aes_pkg::*;

  localparam int Stages = NumRounds + 1;

  // Key registers and expanded schedule.
  logic [63:0] key_high_r, key_low_r;
  block_t      rkey_r [1:Stages-1];
  block_t      rkey_w [Stages];
  logic [3:0]  kstep_r, kstep_nxt;
  logic [7:0]  rcon_r, rcon_nxt;
  logic        kbusy_r, kbusy_nxt;

  // Pipeline.
  block_t      st_w [Stages+1];
  logic        vld_r [Stages];
  logic        adv;

  assign cfg_ch.ready = 1'b1;

  // Key schedule sequencer: restart at every key write.
  always_comb begin
    kstep_nxt = kstep_r;
    rcon_nxt  = rcon_r;
    kbusy_nxt = kbusy_r;
    if (cfg_ch.valid && (cfg_ch.index == CFG_KEY_HIGH || cfg_ch.index == CFG_KEY_LOW)) begin
      kstep_nxt = 4'd1;
      rcon_nxt  = 8'h01;
      kbusy_nxt = 1'b1;
    end else if (kbusy_r) begin
      rcon_nxt  = xtime(rcon_r);
      kstep_nxt = kstep_r + 4'd1;
      if (kstep_r == 4'(NumRounds)) begin
        kbusy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      kstep_r    <= 4'd1;
      rcon_r     <= 8'h01;
      kbusy_r    <= 1'b1;
    end else begin
      kstep_r <= kstep_nxt;
      rcon_r  <= rcon_nxt;
      kbusy_r <= kbusy_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_KEY_HIGH: key_high_r <= cfg_ch.data;
          CFG_KEY_LOW:  key_low_r  <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // Round key 0 follows the key registers; the rest fill one per cycle.
  assign rkey_w[0] = {key_high_r, key_low_r};

  for (genvar k = 1; k < Stages; k++) begin : g_rkey
    always_ff @(posedge clk) begin
      if (kbusy_r && kstep_r == 4'(k)) begin
        rkey_r[k] <= next_key(rkey_w[k-1], rcon_r);
      end
    end
    assign rkey_w[k] = rkey_r[k];
  end

  // Advance whenever the tail is empty or being taken.
  assign adv          = !vld_r[Stages-1] || out_ch.ready;
  assign in_ch.ready  = adv && !kbusy_r;

  block_t in_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      in_r <= {in_ch.data_high, in_ch.data_low} ^ rkey_w[0];
    end
  end
  assign st_w[0] = in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Stages; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_ch.valid && !kbusy_r;
      for (int i = 1; i < Stages; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  for (genvar r = 1; r < Stages; r++) begin : g_round
    aes_round u_round (
      .clk     (clk),
      .en      (adv),
      .last    (r == NumRounds),
      .state_i (st_w[r-1]),
      .rkey_i  (rkey_w[r]),
      .state_o (st_w[r])
    );
  end
  assign st_w[Stages] = st_w[Stages-1];

  assign out_ch.valid     = vld_r[Stages-1];
  assign out_ch.data_high = st_w[Stages][127:64];
  assign out_ch.data_low  = st_w[Stages][63:0];
endmodule

[verif/aes128_block_encrypt_tb_pkg.sv]
package aes128_block_encrypt_tb_pkg;

  import aes_pkg::*;

  // Cipher model: key kept by the testbench, plaintext in, ciphertext out.
  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
  endfunction

  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gf_dbl(a);
    end
    return acc;
  endfunction

  // Inverse as x^254, then the affine map.
  function automatic logic [7:0] subst_byte(input logic [7:0] x);
    logic [7:0] inv, base, y;
    inv = 8'h01;
    base = x;
    for (int e = 0; e < 8; e++) begin
      if ((8'd254 >> e) & 1) inv = gf_times(inv, base);
      base = gf_times(base, base);
    end
    y = 8'h63;
    for (int n = 0; n < 5; n++) y ^= (n == 0) ? inv : ((inv << n) | (inv >> (8 - n)));
    return y;
  endfunction

  class cipher_scoreboard;
    logic [127:0] cipher_key;
    logic [127:0] pending_cipher[$];
    int           mismatches;

    function new();
      cipher_key = '0;
      mismatches = 0;
    endfunction

    function void write_key(input logic [1:0] idx, input logic [63:0] val);
      if (idx == CFG_KEY_HIGH) cipher_key[127:64] = val;
      else if (idx == CFG_KEY_LOW) cipher_key[63:0] = val;
    endfunction

    function logic [127:0] encrypt(input logic [127:0] plain);
      logic [7:0] rk[176];
      logic [7:0] st[16], tmp[16], tw[4], f, rc;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) rk[i] = cipher_key[127-8*i -: 8];
      for (int w = 4; w < 44; w++) begin
        for (int j = 0; j < 4; j++) tw[j] = rk[(w-1)*4+j];
        if (w % 4 == 0) begin
          f = tw[0];
          tw[0] = subst_byte(tw[1]) ^ rc;
          tw[1] = subst_byte(tw[2]);
          tw[2] = subst_byte(tw[3]);
          tw[3] = subst_byte(f);
          rc = gf_dbl(rc);
        end
        for (int j = 0; j < 4; j++) rk[w*4+j] = rk[(w-4)*4+j] ^ tw[j];
      end
      for (int i = 0; i < 16; i++) st[i] = plain[127-8*i -: 8] ^ rk[i];
      for (int r = 1; r <= 10; r++) begin
        for (int c = 0; c < 4; c++)
          for (int q = 0; q < 4; q++) tmp[c*4+q] = subst_byte(st[((c+q)%4)*4+q]);
        for (int c = 0; c < 4; c++) begin
          if (r < 10) begin
            st[c*4]   = gf_times(tmp[c*4], 8'd2) ^ gf_times(tmp[c*4+1], 8'd3) ^
                        tmp[c*4+2] ^ tmp[c*4+3];
            st[c*4+1] = tmp[c*4] ^ gf_times(tmp[c*4+1], 8'd2) ^
                        gf_times(tmp[c*4+2], 8'd3) ^ tmp[c*4+3];
            st[c*4+2] = tmp[c*4] ^ tmp[c*4+1] ^ gf_times(tmp[c*4+2], 8'd2) ^
                        gf_times(tmp[c*4+3], 8'd3);
            st[c*4+3] = gf_times(tmp[c*4], 8'd3) ^ tmp[c*4+1] ^ tmp[c*4+2] ^
                        gf_times(tmp[c*4+3], 8'd2);
          end else begin
            for (int q = 0; q < 4; q++) st[c*4+q] = tmp[c*4+q];
          end
        end
        for (int i = 0; i < 16; i++) st[i] ^= rk[r*16+i];
      end
      for (int i = 0; i < 16; i++) encrypt[127-8*i -: 8] = st[i];
    endfunction

    function void note_plain(input logic [63:0] hi, input logic [63:0] lo);
      pending_cipher.push_back(encrypt({hi, lo}));
    endfunction

    function void check_cipher(input logic [63:0] hi, input logic [63:0] lo);
      logic [127:0] exp_c;
      if (pending_cipher.size() == 0) begin
        $display("%0t: unexpected ciphertext %h_%h", $time, hi, lo);
        mismatches++;
        return;
      end
      exp_c = pending_cipher.pop_front();
      if (exp_c[127:64] !== hi) begin
        $display("%0t: cipher_high expected %h actual %h", $time, exp_c[127:64], hi);
        mismatches++;
      end
      if (exp_c[63:0] !== lo) begin
        $display("%0t: cipher_low expected %h actual %h", $time, exp_c[63:0], lo);
        mismatches++;
      end
    endfunction
  endclass

endpackage

[verif/testbench.sv]
module testbench;

  import aes_pkg::*;
  import aes128_block_encrypt_tb_pkg::*;

  logic clk;
  logic rst_n;

  aes_stream_if in_ch ();
  aes_stream_if out_ch ();
  aes_cfg_if    cfg_ch ();

  aes128_block_encrypt i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  cipher_scoreboard cipher_sb;
  bit long_hold_req;   // ask the receiver for one long stall
  bit rand_out_stall;  // receiver gaps enabled for this phase

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Limit: generous multiple of the slowest run (about 1600 items).
  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random stall per result when enabled, plus one long stretch on request.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold_req) begin
        // hold off while the sender keeps offering, so the pipe fills
        out_ch.ready <= 1'b0;
        for (int k = 0; k < 60; k++) @(posedge clk);
        long_hold_req <= 1'b0;
      end
      gap = rand_out_stall ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      // transfer happens at the first edge with valid high
      do @(posedge clk); while (!out_ch.valid);
      cipher_sb.check_cipher(out_ch.data_high, out_ch.data_low);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cipher_sb.write_key(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain: wait for every expected ciphertext, then a latency margin.
  task automatic drain();
    while (cipher_sb.pending_cipher.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
    drain();
    write_reg(CFG_KEY_HIGH, hi);
    write_reg(CFG_KEY_LOW, lo);
  endtask

  // Send one block; optionally a random gap before it.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_high <= hi;
    in_ch.data_low  <= lo;
    do @(posedge clk); while (!in_ch.ready);
    cipher_sb.note_plain(hi, lo);
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    cipher_sb       = new();
    long_hold_req   = 1'b0;
    rand_out_stall  = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_high = '0;
    in_ch.data_low  = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_KEY_HIGH;
    cfg_ch.data     = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset key (no write yet), then field extremes, back to back.
    send_block('0, '0, 1'b0);
    send_block('1, '1, 1'b0);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    end_burst();

    // Standard test vector key, plus out-of-range indices that must be ignored.
    set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    write_reg(2'd3, '1);
    write_reg(2'd2, 64'h5a5a5a5a5a5a5a5a);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    send_block(64'h8000000000000000, 64'h0000000000000001, 1'b0);
    send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
    end_burst();

    set_key('1, '1);
    send_block('0, '1, 1'b0);
    send_block('1, '0, 1'b0);
    end_burst();

    // Long receiver hold-off while the sender keeps streaming.
    long_hold_req <= 1'b1;
    for (int i = 0; i < 30; i++) send_block(rand64(), rand64(), 1'b0);
    end_burst();

    // Random phases: new key each phase, random gaps on either or both sides.
    for (int ph = 0; ph < 16; ph++) begin
      rand_out_stall <= (ph % 4 != 3);
      case (ph % 5)
        0: set_key('0, rand64());
        1: set_key(rand64(), '1);
        default: set_key(rand64(), rand64());
      endcase
      for (int i = 0; i < 100; i++)
        send_block(rand64(), rand64(), (ph % 4 != 2));
      end_burst();
    end

    drain();
    if (cipher_sb.mismatches == 0 && cipher_sb.pending_cipher.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
rtl/aes_pkg.sv
rtl/aes_stream_if.sv
rtl/aes_cfg_if.sv
rtl/aes_round.sv
rtl/aes128_block_encrypt.sv
verif/aes128_block_encrypt_tb_pkg.sv
verif/testbench.sv
